// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define WSSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define WSSE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wsse_pkg.sv =====
// Shared constants, register map and control types of the wheel slip speed emulator.
package wsse_pkg;

  localparam int THROTTLE_BITS   = 12;
  localparam int SPEED_FRAC_BITS = 16;
  localparam int TICK_MS         = 15;

  localparam int THROTTLE_FULL     = 1 << THROTTLE_BITS;
  localparam int IDLE_THROTTLE_MAX = THROTTLE_FULL / 100;
  localparam int IDLE_LIMIT_MS     = 2000;
  localparam int BRAKE_STEP        = ((5 * TICK_MS) << SPEED_FRAC_BITS) / 1000;
  localparam int MAX_RPM           = 4029;
  localparam int TEST_STEP         = 200;
  localparam int RPM_SAT           = 8191;
  localparam int FORCE_SHIFT       = 16 - THROTTLE_BITS;

  // x / 5 == (x * DIV5_MAGIC) >> DIV5_SHIFT for any 32-bit x
  localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV5_SHIFT = 34;

  localparam int TW = 13;  // throttle field
  localparam int SW = 22;  // speed
  localparam int RW = 13;  // rpm
  localparam int IW = 11;  // idle timer

  localparam int IN_DW  = 32;
  localparam int OUT_DW = 56;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register reset values
  localparam logic [11:0] RST_DRIVE_GAIN = 12'd1584;
  localparam logic [15:0] RST_GRIP_BASE  = 16'd19757;
  localparam logic [15:0] RST_GRIP_DF    = 16'd29019;
  localparam logic [23:0] RST_PROP_GAIN  = 24'd153391;
  localparam logic [15:0] RST_ROLL_LOSS  = 16'd98;
  localparam logic [23:0] RST_DRAG_LOSS  = 24'd226410;
  localparam logic [21:0] RST_SPEED_LIM  = 22'd1920127;
  localparam logic [15:0] RST_RPM_PER_SP = 16'd35204;

  typedef enum logic [2:0] {
    REG_DRIVE_GAIN = 3'd0,
    REG_GRIP_BASE  = 3'd1,
    REG_GRIP_DF    = 3'd2,
    REG_PROP_GAIN  = 3'd3,
    REG_ROLL_LOSS  = 3'd4,
    REG_DRAG_LOSS  = 3'd5,
    REG_SPEED_LIM  = 3'd6,
    REG_RPM_PER_SP = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] drive_force_gain;
    logic [15:0] grip_base;
    logic [15:0] grip_downforce;
    logic [23:0] propulsion_gain;
    logic [15:0] rolling_loss;
    logic [23:0] drag_loss;
    logic [21:0] speed_limit;
    logic [15:0] rpm_per_speed;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VSQ, ST_GD_HI, ST_GD_LO, ST_FL, ST_FR, ST_G45, ST_FORCE,
    ST_INC, ST_DRAG, ST_SPEED, ST_RPM, ST_WHEEL, ST_PARK, ST_OUT
  } st_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_VSQ, OP_GD_HI, OP_GD_LO, OP_FL, OP_FR, OP_G45, OP_FORCE,
    OP_INC, OP_DRAG, OP_SPEED, OP_RPM, OP_WHEEL, OP_PARK, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic drive_in;  // beat on the input runs the physics path
    logic out_busy;  // output register full and not being drained
  } sts_t;

endpackage

// ===== rtl/wsse_regs.sv =====
// Configuration register file behind the APB-style port.
module wsse_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wsse_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [wsse_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [wsse_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output wsse_pkg::cfg_t              cfg
);

  wsse_pkg::cfg_t     cfg_r, cfg_nxt;
  wsse_pkg::cfg_idx_t idx;
  logic               wr;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = wsse_pkg::cfg_idx_t'(cfg_paddr[4:2]);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        wsse_pkg::REG_DRIVE_GAIN: cfg_nxt.drive_force_gain = cfg_pwdata[11:0];
        wsse_pkg::REG_GRIP_BASE:  cfg_nxt.grip_base        = cfg_pwdata[15:0];
        wsse_pkg::REG_GRIP_DF:    cfg_nxt.grip_downforce   = cfg_pwdata[15:0];
        wsse_pkg::REG_PROP_GAIN:  cfg_nxt.propulsion_gain  = cfg_pwdata[23:0];
        wsse_pkg::REG_ROLL_LOSS:  cfg_nxt.rolling_loss     = cfg_pwdata[15:0];
        wsse_pkg::REG_DRAG_LOSS:  cfg_nxt.drag_loss        = cfg_pwdata[23:0];
        wsse_pkg::REG_SPEED_LIM:  cfg_nxt.speed_limit      = cfg_pwdata[21:0];
        wsse_pkg::REG_RPM_PER_SP: cfg_nxt.rpm_per_speed    = cfg_pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wsse_pkg::REG_DRIVE_GAIN: cfg_prdata = 32'(cfg_r.drive_force_gain);
      wsse_pkg::REG_GRIP_BASE:  cfg_prdata = 32'(cfg_r.grip_base);
      wsse_pkg::REG_GRIP_DF:    cfg_prdata = 32'(cfg_r.grip_downforce);
      wsse_pkg::REG_PROP_GAIN:  cfg_prdata = 32'(cfg_r.propulsion_gain);
      wsse_pkg::REG_ROLL_LOSS:  cfg_prdata = 32'(cfg_r.rolling_loss);
      wsse_pkg::REG_DRAG_LOSS:  cfg_prdata = 32'(cfg_r.drag_loss);
      wsse_pkg::REG_SPEED_LIM:  cfg_prdata = 32'(cfg_r.speed_limit);
      wsse_pkg::REG_RPM_PER_SP: cfg_prdata = 32'(cfg_r.rpm_per_speed);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_force_gain <= wsse_pkg::RST_DRIVE_GAIN;
      cfg_r.grip_base        <= wsse_pkg::RST_GRIP_BASE;
      cfg_r.grip_downforce   <= wsse_pkg::RST_GRIP_DF;
      cfg_r.propulsion_gain  <= wsse_pkg::RST_PROP_GAIN;
      cfg_r.rolling_loss     <= wsse_pkg::RST_ROLL_LOSS;
      cfg_r.drag_loss        <= wsse_pkg::RST_DRAG_LOSS;
      cfg_r.speed_limit      <= wsse_pkg::RST_SPEED_LIM;
      cfg_r.rpm_per_speed    <= wsse_pkg::RST_RPM_PER_SP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/wsse_ctrl.sv =====
// Step sequencer: walks the datapath through one tick.
module wsse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  wsse_pkg::sts_t sts,
  output wsse_pkg::cmd_t cmd
);

  wsse_pkg::st_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wsse_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = wsse_pkg::OP_NONE;
    unique case (st_r)
      wsse_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          st_nxt   = sts.drive_in ? wsse_pkg::ST_VSQ : wsse_pkg::ST_PARK;
        end
      end
      wsse_pkg::ST_VSQ: begin
        cmd.op = wsse_pkg::OP_VSQ;
        st_nxt = wsse_pkg::ST_GD_HI;
      end
      wsse_pkg::ST_GD_HI: begin
        cmd.op = wsse_pkg::OP_GD_HI;
        st_nxt = wsse_pkg::ST_GD_LO;
      end
      wsse_pkg::ST_GD_LO: begin
        cmd.op = wsse_pkg::OP_GD_LO;
        st_nxt = wsse_pkg::ST_FL;
      end
      wsse_pkg::ST_FL: begin
        cmd.op = wsse_pkg::OP_FL;
        st_nxt = wsse_pkg::ST_FR;
      end
      wsse_pkg::ST_FR: begin
        cmd.op = wsse_pkg::OP_FR;
        st_nxt = wsse_pkg::ST_G45;
      end
      wsse_pkg::ST_G45: begin
        cmd.op = wsse_pkg::OP_G45;
        st_nxt = wsse_pkg::ST_FORCE;
      end
      wsse_pkg::ST_FORCE: begin
        cmd.op = wsse_pkg::OP_FORCE;
        st_nxt = wsse_pkg::ST_INC;
      end
      wsse_pkg::ST_INC: begin
        cmd.op = wsse_pkg::OP_INC;
        st_nxt = wsse_pkg::ST_DRAG;
      end
      wsse_pkg::ST_DRAG: begin
        cmd.op = wsse_pkg::OP_DRAG;
        st_nxt = wsse_pkg::ST_SPEED;
      end
      wsse_pkg::ST_SPEED: begin
        cmd.op = wsse_pkg::OP_SPEED;
        st_nxt = wsse_pkg::ST_RPM;
      end
      wsse_pkg::ST_RPM: begin
        cmd.op = wsse_pkg::OP_RPM;
        st_nxt = wsse_pkg::ST_WHEEL;
      end
      wsse_pkg::ST_WHEEL: begin
        cmd.op = wsse_pkg::OP_WHEEL;
        st_nxt = wsse_pkg::ST_OUT;
      end
      wsse_pkg::ST_PARK: begin
        cmd.op = wsse_pkg::OP_PARK;
        st_nxt = wsse_pkg::ST_OUT;
      end
      wsse_pkg::ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.op = wsse_pkg::OP_OUT;
          st_nxt = wsse_pkg::ST_IDLE;
        end
      end
      default: st_nxt = wsse_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/wsse_dp.sv =====
// Datapath: shared multiplier, vehicle state and the output register.
module wsse_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsse_pkg::cmd_t              cmd,
  input  wsse_pkg::cfg_t              cfg,
  input  logic [wsse_pkg::IN_DW-1:0]  in_tdata,
  output wsse_pkg::sts_t              sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [wsse_pkg::OUT_DW-1:0] out_tdata
);

  localparam int TW = wsse_pkg::TW;
  localparam int SW = wsse_pkg::SW;
  localparam int RW = wsse_pkg::RW;
  localparam int IW = wsse_pkg::IW;

  // latched beat
  logic [TW-1:0] tl_r, tr_r, tl_sat, tr_sat;
  logic          test_r;

  // architectural state
  logic [SW-1:0] speed_r, speed_nxt;
  logic [IW-1:0] idle_r, idle_nxt;
  logic [RW-1:0] rpm_l_r, rpm_l_nxt, rpm_r_r, rpm_r_nxt;
  logic          slip_l_r, slip_l_nxt, slip_r_r, slip_r_nxt;

  // working registers
  logic [63:0]        prod_r, mul_p;
  logic [31:0]        mul_a, mul_b;
  logic [43:0]        vsq_r;
  logic [37:0]        acc_r;
  logic [28:0]        grip_r, fl_raw_r, fr_raw_r;
  logic [29:0]        fsum_r;
  logic signed [25:0] base_r;

  logic                      out_valid_r;
  logic [wsse_pkg::OUT_DW-1:0] out_data_r;

  // combinational helpers
  logic [59:0]        df_sum;
  logic [28:0]        g45, fl_use, fr_use;
  logic               slip_l_c, slip_r_c;
  logic               idle_c, brake_c;
  logic [IW:0]        idle_sum;
  logic signed [25:0] ns, lim_s;
  logic [13:0]        spd_rpm14;
  logic [RW-1:0]      spd_rpm;

  function automatic logic [RW-1:0] wheel_rpm(input logic slip, input logic [RW-1:0] rpm,
                                              input logic [RW-1:0] follow);
    logic [RW-1:0] res;
    if (!slip) begin
      res = follow;
    end else if (rpm >= RW'(wsse_pkg::MAX_RPM)) begin
      res = RW'(wsse_pkg::MAX_RPM);
    end else begin
      res = rpm + RW'(wsse_pkg::TICK_MS);
    end
    return res;
  endfunction

  assign tl_sat = (in_tdata[12:0] > TW'(wsse_pkg::THROTTLE_FULL)) ?
                  TW'(wsse_pkg::THROTTLE_FULL) : in_tdata[12:0];
  assign tr_sat = (in_tdata[25:13] > TW'(wsse_pkg::THROTTLE_FULL)) ?
                  TW'(wsse_pkg::THROTTLE_FULL) : in_tdata[25:13];

  assign sts.drive_in = in_tdata[26] && !in_tdata[27];
  assign sts.out_busy = out_valid_r && !out_tready;

  // operand select for the one shared 32x32 multiplier
  always_comb begin
    case (cmd.op)
      wsse_pkg::OP_VSQ: begin
        mul_a = 32'(speed_r);
        mul_b = 32'(speed_r);
      end
      wsse_pkg::OP_GD_HI: begin
        mul_a = 32'(cfg.grip_downforce);
        mul_b = 32'(prod_r[43:22]);
      end
      wsse_pkg::OP_GD_LO: begin
        mul_a = 32'(cfg.grip_downforce);
        mul_b = 32'(vsq_r[21:0]);
      end
      wsse_pkg::OP_FL: begin
        mul_a = 32'(cfg.drive_force_gain);
        mul_b = 32'(tl_r);
      end
      wsse_pkg::OP_FR: begin
        mul_a = 32'(cfg.drive_force_gain);
        mul_b = 32'(tr_r);
      end
      wsse_pkg::OP_G45: begin
        mul_a = {1'b0, grip_r, 2'b00};
        mul_b = wsse_pkg::DIV5_MAGIC;
      end
      wsse_pkg::OP_INC: begin
        mul_a = 32'(fsum_r);
        mul_b = 32'(cfg.propulsion_gain);
      end
      wsse_pkg::OP_DRAG: begin
        mul_a = 32'(vsq_r[43:16]);
        mul_b = 32'(cfg.drag_loss);
      end
      wsse_pkg::OP_RPM: begin
        mul_a = 32'(speed_r);
        mul_b = 32'(cfg.rpm_per_speed);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // downforce grip = (gd * vsq) >> 32, vsq split at bit 22
  assign df_sum = {acc_r, 22'd0} + {22'd0, prod_r[37:0]};

  assign g45      = prod_r[wsse_pkg::DIV5_SHIFT +: 29];
  assign slip_l_c = fl_raw_r > grip_r;
  assign slip_r_c = fr_raw_r > grip_r;
  assign fl_use   = slip_l_c ? g45 : fl_raw_r;
  assign fr_use   = slip_r_c ? g45 : fr_raw_r;

  assign idle_c   = (tl_r <= TW'(wsse_pkg::IDLE_THROTTLE_MAX)) &&
                    (tr_r <= TW'(wsse_pkg::IDLE_THROTTLE_MAX));
  assign idle_sum = {1'b0, idle_r} + (IW+1)'(wsse_pkg::TICK_MS);
  assign brake_c  = idle_c && (idle_sum >= (IW+1)'(wsse_pkg::IDLE_LIMIT_MS));
  assign ns       = base_r - $signed({6'd0, prod_r[51:32]}) -
                    (brake_c ? 26'(wsse_pkg::BRAKE_STEP) : 26'sd0);
  assign lim_s    = $signed({4'd0, cfg.speed_limit});

  assign spd_rpm14 = prod_r[37:24];
  assign spd_rpm   = (spd_rpm14 > 14'(wsse_pkg::RPM_SAT)) ? RW'(wsse_pkg::RPM_SAT) :
                     spd_rpm14[RW-1:0];

  always_comb begin
    speed_nxt  = speed_r;
    idle_nxt   = idle_r;
    rpm_l_nxt  = rpm_l_r;
    rpm_r_nxt  = rpm_r_r;
    slip_l_nxt = slip_l_r;
    slip_r_nxt = slip_r_r;
    case (cmd.op)
      wsse_pkg::OP_FORCE: begin
        slip_l_nxt = slip_l_c;
        slip_r_nxt = slip_r_c;
      end
      wsse_pkg::OP_SPEED: begin
        if (!idle_c) begin
          idle_nxt = '0;
        end else if (brake_c) begin
          idle_nxt = IW'(wsse_pkg::IDLE_LIMIT_MS);
        end else begin
          idle_nxt = idle_sum[IW-1:0];
        end
        if (ns >= lim_s) begin
          speed_nxt = cfg.speed_limit;
        end else if (ns < 0) begin
          speed_nxt = '0;
        end else begin
          speed_nxt = ns[SW-1:0];
        end
      end
      wsse_pkg::OP_WHEEL: begin
        rpm_l_nxt = wheel_rpm(slip_l_r, rpm_l_r, spd_rpm);
        rpm_r_nxt = wheel_rpm(slip_r_r, rpm_r_r, spd_rpm);
      end
      wsse_pkg::OP_PARK: begin
        speed_nxt = '0;
        if (test_r) begin
          // ramp pattern, wraps to zero at the top
          rpm_l_nxt = (rpm_l_r >= RW'(wsse_pkg::MAX_RPM)) ? '0 :
                      rpm_l_r + RW'(wsse_pkg::TEST_STEP);
          rpm_r_nxt = rpm_l_nxt;
        end else begin
          rpm_l_nxt = '0;
          rpm_r_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      idle_r      <= '0;
      rpm_l_r     <= '0;
      rpm_r_r     <= '0;
      slip_l_r    <= 1'b0;
      slip_r_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      speed_r  <= speed_nxt;
      idle_r   <= idle_nxt;
      rpm_l_r  <= rpm_l_nxt;
      rpm_r_r  <= rpm_r_nxt;
      slip_l_r <= slip_l_nxt;
      slip_r_r <= slip_r_nxt;
      if (cmd.op == wsse_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.load) begin
      tl_r   <= tl_sat;
      tr_r   <= tr_sat;
      test_r <= in_tdata[27];
    end
    case (cmd.op)
      wsse_pkg::OP_GD_HI: vsq_r    <= prod_r[43:0];
      wsse_pkg::OP_GD_LO: acc_r    <= prod_r[37:0];
      wsse_pkg::OP_FL:    grip_r   <= {1'b0, cfg.grip_base, 12'd0} + {1'b0, df_sum[59:32]};
      wsse_pkg::OP_FR:    fl_raw_r <= {prod_r[24:0], wsse_pkg::FORCE_SHIFT'(0)};
      wsse_pkg::OP_G45:   fr_raw_r <= {prod_r[24:0], wsse_pkg::FORCE_SHIFT'(0)};
      wsse_pkg::OP_FORCE: fsum_r   <= {1'b0, fl_use} + {1'b0, fr_use};
      wsse_pkg::OP_DRAG:  base_r   <= $signed({4'd0, speed_r}) + $signed({4'd0, prod_r[53:32]})
                                      - $signed({10'd0, cfg.rolling_loss});
      wsse_pkg::OP_OUT:   out_data_r <= {6'd0, speed_r, slip_r_r, slip_l_r, rpm_r_r, rpm_l_r};
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/wheel_slip_speed_emulator_unit.sv =====
// Top level of the wheel slip speed emulator.
// Each input beat is one 15 ms simulation tick carrying both throttles, the
// drive enable and the test mode; each tick returns exactly one output beat
// with both wheel RPMs, both slip flags and the vehicle speed after the tick.
// A driving tick runs from its acceptance slot to the result load through
// the accept cycle, twelve datapath steps and the output load. Its length is
// set by the single shared 32x32 multiplier, which is used in nine passes
// (speed squared, two downforce halves, two wheel forces, the 0.8 grip cut,
// propulsion, drag and the speed-to-RPM scale). A test-mode or disabled tick
// runs the accept, park and output steps. The result sits in an output
// register, so the next beat is accepted while the previous result still
// waits; the sequencer only holds before loading a new result into a
// still-full output register. Configuration registers sit at byte address
// 4*index on the APB-style port; write them only while no tick is in flight.
module wheel_slip_speed_emulator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input beat
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [12:0] throttle_left, [25:13] throttle_right, [26] drive_enable,
  // [27] test_mode, [31:28] zero
  input  logic [wsse_pkg::IN_DW-1:0]  in_tdata,
  // result beat
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [12:0] rpm_left, [25:13] rpm_right, [26] slip_left, [27] slip_right,
  // [49:28] vehicle_speed, [55:50] zero
  output logic [wsse_pkg::OUT_DW-1:0] out_tdata,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wsse_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [wsse_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [wsse_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  wsse_pkg::cfg_t cfg;
  wsse_pkg::cmd_t cmd;
  wsse_pkg::sts_t sts;

  // register file: all tunables, reset to the vehicle defaults
  wsse_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: one step per cycle unless a full output register holds it, branches on test/enable at accept
  wsse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: multiplier, speed/idle/rpm/slip state and output register
  wsse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/wsse_checker.sv =====
// Port-level checks of the emulator, bound to the top level.
`include "assert_macros.svh"

module wsse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [wsse_pkg::OUT_DW-1:0] out_tdata
);

  // a stalled result beat holds
  `WSSE_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "result beat dropped or changed under stall")
  // the output register comes out of reset empty
  `WSSE_ASSERT_RST(a_out_rst, !rst_n |=> !out_tvalid, "result beat valid right after reset")
  // one tick at a time: the sequencer leaves idle on every accepted beat
  `WSSE_ASSERT(a_one_tick, (in_tvalid && in_tready) |=> !in_tready, "second beat taken while a tick is in flight")
  // no result can be produced in the cycle right after an accept
  `WSSE_ASSERT(a_no_early, (in_tvalid && in_tready) |=> !$rose(out_tvalid), "result appeared before the tick was worked")

endmodule

bind wheel_slip_speed_emulator_unit wsse_checker u_wsse_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking bench for the wheel slip speed emulator: directed ticks, then random drive cycles.
module tb_top;

  // Physics constants of the tick.
  localparam int THR_BITS      = 12;
  localparam int THR_FULL      = 1 << THR_BITS;
  localparam int Q             = 16;           // speed fraction bits
  localparam int TICK_STEP_MS  = 15;
  localparam int IDLE_HOLD_MS  = 2000;
  localparam int BRAKE_Q       = ((5 * TICK_STEP_MS) << Q) / 1000;
  localparam int RAMP_CAP      = 4029;
  localparam int TEST_RAMP     = 200;
  localparam int RPM_CEIL      = 8191;
  localparam int SPEED_CEIL    = 4194303;

  localparam int TICK_BUDGET   = 900;          // random ticks stop here
  localparam int PHASE_TICKS   = 80;           // ticks per register setting
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_CAP     = 40;

  // Register widths and reset values, in register-map order.
  localparam int REG_W [8] = '{12, 16, 16, 24, 16, 24, 22, 16};
  localparam logic [31:0] RESET_VAL [8] = '{
    32'(wsse_pkg::RST_DRIVE_GAIN), 32'(wsse_pkg::RST_GRIP_BASE),
    32'(wsse_pkg::RST_GRIP_DF), 32'(wsse_pkg::RST_PROP_GAIN),
    32'(wsse_pkg::RST_ROLL_LOSS), 32'(wsse_pkg::RST_DRAG_LOSS),
    32'(wsse_pkg::RST_SPEED_LIM), 32'(wsse_pkg::RST_RPM_PER_SP)
  };

  // Register setting styles, one per configuration phase.
  typedef enum int { SET_DEFAULT, SET_RANDOM, SET_MAX, SET_TUNED, SET_ZERO } setting_t;

  // Kinds of random tick run.
  typedef enum int {
    RUN_CRUISE, RUN_LAUNCH, RUN_TEST_RAMP, RUN_STOP, RUN_NOISE, RUN_COAST
  } run_kind_t;

  typedef struct packed {
    logic [12:0] tl;
    logic [12:0] tr;
    logic        en;
    logic        test;
  } tick_t;

  typedef struct packed {
    logic [12:0] rpm_l;
    logic [12:0] rpm_r;
    logic        slip_l;
    logic        slip_r;
    logic [21:0] speed;
  } wheel_t;

  // Directed row: stimulus, plus the result where it is obvious by hand.
  typedef struct packed {
    logic        typed;
    logic [12:0] tl;
    logic [12:0] tr;
    logic        en;
    logic        test;
    logic [12:0] rpm_l;
    logic [12:0] rpm_r;
    logic        slip_l;
    logic        slip_r;
    logic [21:0] speed;
  } plan_row_t;

  localparam int PLAN_LEN = 20;

  plan_row_t plan [PLAN_LEN] = '{
    // out of reset, disabled: everything zero
    '{1'b1, 13'd0,    13'd0,    1'b0, 1'b0, 13'd0,   13'd0,   1'b0, 1'b0, 22'd0},
    // test mode ramps both RPMs by 200, throttles at field max are ignored
    '{1'b1, 13'd8191, 13'd8191, 1'b0, 1'b1, 13'd200, 13'd200, 1'b0, 1'b0, 22'd0},
    '{1'b1, 13'd0,    13'd0,    1'b0, 1'b1, 13'd400, 13'd400, 1'b0, 1'b0, 22'd0},
    // disabled clears the RPMs
    '{1'b1, 13'd4096, 13'd4096, 1'b0, 1'b0, 13'd0,   13'd0,   1'b0, 1'b0, 22'd0},
    // test mode wins over drive enable
    '{1'b1, 13'd4096, 13'd0,    1'b1, 1'b1, 13'd200, 13'd200, 1'b0, 1'b0, 22'd0},
    // from here on the predictor decides
    '{1'b0, 13'd4096, 13'd4096, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // full, slips
    '{1'b0, 13'd8191, 13'd0,    1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // saturation
    '{1'b0, 13'd0,    13'd8191, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd5461, 13'd2730, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // bit patterns
    '{1'b0, 13'd2730, 13'd5461, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd1000, 13'd3000, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // grips
    '{1'b0, 13'd2000, 13'd2000, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd40,   13'd40,   1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // idle edge
    '{1'b0, 13'd41,   13'd40,   1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // just above
    '{1'b0, 13'd40,   13'd41,   1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd1,    13'd0,    1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd0,    13'd0,    1'b1, 1'b1, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // test after slip
    '{1'b0, 13'd0,    13'd0,    1'b0, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},  // slip held
    '{1'b0, 13'd4096, 13'd1,    1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0},
    '{1'b0, 13'd4095, 13'd8190, 1'b1, 1'b0, 13'd0, 13'd0, 1'b0, 1'b0, 22'd0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  // [12:0] throttle_left, [25:13] throttle_right, [26] drive_enable, [27] test_mode
  logic [wsse_pkg::IN_DW-1:0]    in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  // [12:0] rpm_left, [25:13] rpm_right, [26] slip_left, [27] slip_right,
  // [49:28] vehicle_speed
  logic [wsse_pkg::OUT_DW-1:0]   out_tdata;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [wsse_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [wsse_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [wsse_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  // Shadow of the block: registers and vehicle state as the predictor sees them.
  logic [31:0] reg_val [8];
  logic [21:0] car_speed;
  logic [10:0] coast_ms;
  logic [12:0] rpm_l, rpm_r;
  logic        slip_l, slip_r;

  wheel_t wheel_due_q [$];   // predicted result beats, oldest first
  int     mismatch_count;
  int     ticks_sent;
  int     beats_seen;
  int     cycles_run = 0;
  bit     gaps_on;           // both sides insert random idle cycles when set

  wheel_slip_speed_emulator_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("wheel_slip_speed_emulator_unit verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH beat %0d %s: got %0d want %0d", beats_seen, what, got, want);
    mismatch_count++;
  endtask

  // One 15 ms tick of the vehicle. Updates the shadow state and returns the beat.
  function automatic wheel_t advance_vehicle(tick_t t);
    longint unsigned gain, gbase, gdf, prop, rloss, dloss, slim, rps;
    longint unsigned tl, tr, v, vsq, grip, fl, fr, inc, roll, drag, lim, srpm, nv;
    longint          ns;
    wheel_t          r;
    gain  = reg_val[wsse_pkg::REG_DRIVE_GAIN];
    gbase = reg_val[wsse_pkg::REG_GRIP_BASE];
    gdf   = reg_val[wsse_pkg::REG_GRIP_DF];
    prop  = reg_val[wsse_pkg::REG_PROP_GAIN];
    rloss = reg_val[wsse_pkg::REG_ROLL_LOSS];
    dloss = reg_val[wsse_pkg::REG_DRAG_LOSS];
    slim  = reg_val[wsse_pkg::REG_SPEED_LIM];
    rps   = reg_val[wsse_pkg::REG_RPM_PER_SP];
    tl = (t.tl > THR_FULL) ? THR_FULL : t.tl;
    tr = (t.tr > THR_FULL) ? THR_FULL : t.tr;
    if (t.test) begin
      car_speed = '0;
      rpm_l = (rpm_l >= RAMP_CAP) ? 13'd0 : 13'(rpm_l + TEST_RAMP);
      rpm_r = rpm_l;
    end else if (t.en) begin
      v    = car_speed;
      vsq  = v * v;
      // grip grows with speed squared (downforce)
      grip = (gbase << 12) + ((gdf * vsq) >> (2 * Q));
      fl   = (gain * tl) << (16 - THR_BITS);
      fr   = (gain * tr) << (16 - THR_BITS);
      if (fl > grip) begin
        slip_l = 1'b1;
        fl = (grip * 4) / 5;
      end else begin
        slip_l = 1'b0;
      end
      if (fr > grip) begin
        slip_r = 1'b1;
        fr = (grip * 4) / 5;
      end else begin
        slip_r = 1'b0;
      end
      inc  = ((fl + fr) * prop) >> (48 - Q);
      roll = (rloss << Q) >> 16;
      drag = ((vsq >> Q) * dloss) >> 32;
      ns   = longint'(v + inc) - longint'(roll) - longint'(drag);
      // idle throttle on both sides counts toward the parking brake
      if (tl * 100 <= THR_FULL && tr * 100 <= THR_FULL) begin
        if (coast_ms + TICK_STEP_MS >= IDLE_HOLD_MS) begin
          ns = ns - BRAKE_Q;
          coast_ms = 11'(IDLE_HOLD_MS);
        end else begin
          coast_ms = 11'(coast_ms + TICK_STEP_MS);
        end
      end else begin
        coast_ms = '0;
      end
      lim = (slim << Q) >> 16;
      if (lim > SPEED_CEIL) lim = SPEED_CEIL;
      if (ns >= longint'(lim)) ns = longint'(lim);
      if (ns < 0) ns = 0;
      car_speed = ns[21:0];
      nv   = car_speed;
      srpm = (nv * rps) >> (Q + 8);
      if (srpm > RPM_CEIL) srpm = RPM_CEIL;
      // slipping wheel spins up on its own, gripping wheel follows the road
      if (slip_l) rpm_l = (rpm_l >= RAMP_CAP) ? 13'(RAMP_CAP) : 13'(rpm_l + TICK_STEP_MS);
      else        rpm_l = srpm[12:0];
      if (slip_r) rpm_r = (rpm_r >= RAMP_CAP) ? 13'(RAMP_CAP) : 13'(rpm_r + TICK_STEP_MS);
      else        rpm_r = srpm[12:0];
    end else begin
      // stopped: slip flags and idle timer hold
      car_speed = '0;
      rpm_l     = '0;
      rpm_r     = '0;
    end
    r.rpm_l  = rpm_l;
    r.rpm_r  = rpm_r;
    r.slip_l = slip_l;
    r.slip_r = slip_r;
    r.speed  = car_speed;
    return r;
  endfunction

  // Enters and leaves on a falling edge. Valid stays up across back-to-back beats.
  task automatic send_tick(input tick_t t, input logic typed, input wheel_t typed_want);
    int     gap;
    wheel_t predicted;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {4'b0, t.test, t.en, t.tr, t.tl};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = advance_vehicle(t);
    wheel_due_q.push_back(typed ? typed_want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every predicted beat has come back.
  task automatic hold_until_drained(input int extra);
    in_tvalid = 1'b0;
    while (wheel_due_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic cfg_access(input int idx, input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = write;
    cfg_paddr   = {wsse_pkg::cfg_idx_t'(idx), 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Writes all eight registers in one style, then reads each one back.
  task automatic apply_setting(input setting_t mode);
    logic [31:0] val;
    logic [31:0] rd;
    logic [31:0] mask;
    for (int i = 0; i < 8; i++) begin
      mask = 32'((64'd1 << REG_W[i]) - 1);
      case (mode)
        SET_DEFAULT: val = RESET_VAL[i];
        SET_MAX:     val = mask;
        SET_ZERO:    val = '0;
        SET_RANDOM: begin
          case ($urandom_range(0, 3))
            0:       val = '0;
            1:       val = mask;
            default: val = $urandom & mask;
          endcase
        end
        default: begin
          // near defaults, but pushed hard so the speed limit and RPM clip show up
          case (wsse_pkg::cfg_idx_t'(i))
            wsse_pkg::REG_PROP_GAIN:  val = $urandom_range(1000000, 16777215);
            wsse_pkg::REG_SPEED_LIM:  val = $urandom_range(100000, 1500000);
            wsse_pkg::REG_RPM_PER_SP: val = $urandom & mask;
            wsse_pkg::REG_GRIP_DF:    val = $urandom & mask;
            default:                  val = RESET_VAL[i];
          endcase
        end
      endcase
      cfg_access(i, 1'b1, val, rd);
      reg_val[i] = val;
    end
    for (int i = 0; i < 8; i++) begin
      cfg_access(i, 1'b0, '0, rd);
      if (rd !== reg_val[i]) flag_mismatch($sformatf("readback reg %0d", i), rd, reg_val[i]);
    end
  endtask

  function automatic logic [12:0] pick_throttle();
    case ($urandom_range(0, 4))
      0:       return 13'($urandom_range(0, 40));
      1:       return 13'($urandom_range(41, 4096));
      2:       return 13'(THR_FULL);
      3:       return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic tick_t make_tick(input run_kind_t kind);
    tick_t t;
    t.tl   = pick_throttle();
    t.tr   = pick_throttle();
    t.en   = 1'b1;
    t.test = 1'b0;
    case (kind)
      RUN_LAUNCH: begin
        t.tl = 13'($urandom_range(3000, 8191));
        t.tr = 13'($urandom_range(3000, 8191));
      end
      RUN_COAST: begin
        t.tl = 13'($urandom_range(0, 40));
        t.tr = 13'($urandom_range(0, 40));
      end
      RUN_TEST_RAMP: begin
        t.en   = 1'($urandom_range(0, 1));
        t.test = 1'b1;
      end
      RUN_STOP: t.en = 1'b0;
      RUN_NOISE: begin
        t.tl   = 13'($urandom_range(0, 8191));
        t.tr   = 13'($urandom_range(0, 8191));
        t.en   = ($urandom_range(0, 3) != 0);
        t.test = ($urandom_range(0, 3) == 0);
      end
      default: ;
    endcase
    return t;
  endfunction

  // Result sink: random back-pressure per beat, checks every beat in order.
  initial begin : result_sink
    int     stall;
    wheel_t got;
    wheel_t want;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = gaps_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!(rst_n && out_tvalid)) @(posedge clk);
      got.rpm_l  = out_tdata[12:0];
      got.rpm_r  = out_tdata[25:13];
      got.slip_l = out_tdata[26];
      got.slip_r = out_tdata[27];
      got.speed  = out_tdata[49:28];
      if (wheel_due_q.size() == 0) begin
        flag_mismatch("unexpected beat", out_tdata, 0);
      end else begin
        want = wheel_due_q.pop_front();
        if (got.rpm_l !== want.rpm_l)   flag_mismatch("rpm_left", got.rpm_l, want.rpm_l);
        if (got.rpm_r !== want.rpm_r)   flag_mismatch("rpm_right", got.rpm_r, want.rpm_r);
        if (got.slip_l !== want.slip_l) flag_mismatch("slip_left", got.slip_l, want.slip_l);
        if (got.slip_r !== want.slip_r) flag_mismatch("slip_right", got.slip_r, want.slip_r);
        if (got.speed !== want.speed)   flag_mismatch("vehicle_speed", got.speed, want.speed);
      end
      beats_seen++;
    end
  end

  // Stimulus: reset, directed rows, then phases of random runs under different settings.
  initial begin : stimulus
    tick_t     t;
    wheel_t    typed_want;
    run_kind_t kind;
    int        run_len;
    int        phase;
    int        phase_end;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    mismatch_count = 0;
    ticks_sent     = 0;
    beats_seen     = 0;
    gaps_on        = 1'b1;
    car_speed      = '0;
    coast_ms       = '0;
    rpm_l          = '0;
    rpm_r          = '0;
    slip_l         = 1'b0;
    slip_r         = 1'b0;
    for (int i = 0; i < 8; i++) reg_val[i] = RESET_VAL[i];

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows run on the reset register values
    for (int k = 0; k < PLAN_LEN; k++) begin
      t.tl              = plan[k].tl;
      t.tr              = plan[k].tr;
      t.en              = plan[k].en;
      t.test            = plan[k].test;
      typed_want.rpm_l  = plan[k].rpm_l;
      typed_want.rpm_r  = plan[k].rpm_r;
      typed_want.slip_l = plan[k].slip_l;
      typed_want.slip_r = plan[k].slip_r;
      typed_want.speed  = plan[k].speed;
      send_tick(t, plan[k].typed, typed_want);
    end

    phase = 0;
    while (ticks_sent < TICK_BUDGET) begin
      // registers only change with nothing in flight
      hold_until_drained(SETTLE_CYCLES);
      apply_setting(setting_t'(phase % 5));
      phase_end = ticks_sent + PHASE_TICKS;

      // every third phase: get moving, then coast long enough to engage the brake
      if (phase % 3 == 1) begin
        gaps_on = 1'b0;
        repeat (15) send_tick(make_tick(RUN_LAUNCH), 1'b0, '0);
        repeat (150) send_tick(make_tick(RUN_COAST), 1'b0, '0);
      end

      while (ticks_sent < phase_end) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 5) == 0) hold_until_drained(0);
        case ($urandom_range(0, 9))
          0, 1, 2: kind = RUN_CRUISE;
          3:       kind = RUN_LAUNCH;
          4:       kind = RUN_TEST_RAMP;
          5:       kind = RUN_STOP;
          6, 7:    kind = RUN_NOISE;
          default: kind = RUN_COAST;
        endcase
        case (kind)
          RUN_TEST_RAMP: run_len = $urandom_range(15, 30);  // the longer runs wrap even from zero
          RUN_STOP:      run_len = $urandom_range(1, 3);
          default:       run_len = $urandom_range(5, 30);
        endcase
        repeat (run_len) send_tick(make_tick(kind), 1'b0, '0);
      end
      phase++;
    end

    in_tvalid = 1'b0;
    while (wheel_due_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("wheel_slip_speed_emulator_unit verification clean");
    end else begin
      $display("wheel_slip_speed_emulator_unit verification failed");
    end
    $finish;
  end

endmodule
